// File: hdl/resize_scale_factor_calc_core_defines.svh
// Assertion macros for the resize scale-step calculator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RESIZE_SCALE_FACTOR_CALC_CORE_DEFINES_SVH
`define RESIZE_SCALE_FACTOR_CALC_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define RSFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsfc assertion failed");

// Next-cycle implication
`define RSFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsfc assertion failed");

`else

`define RSFC_ASSERT_IMP(lbl, ante, cons)
`define RSFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hdl/rsfc_pkg.sv
package rsfc_pkg;

  // Engine variant codes
  localparam logic [1:0] VAR_BASIC    = 2'd0;
  localparam logic [1:0] VAR_REPEAT   = 2'd1;
  localparam logic [1:0] VAR_PASSBAND = 2'd2;

  // 4.12 step constants
  localparam logic [11:0] FRAC_GRID    = 12'hff8;
  localparam logic [11:0] FRAC_HALF    = 12'h800;
  localparam logic [11:0] FRAC_QUARTER = 12'h400;
  localparam logic [11:0] FRAC_EIGHTH  = 12'h200;
  localparam logic [3:0]  MANT_MAX     = 4'd15;

  // Repeat counts for exact upscale by 2, 4 and 8
  localparam logic [2:0] REP_NONE = 3'd0;
  localparam logic [2:0] REP_X2   = 3'd1;
  localparam logic [2:0] REP_X4   = 3'd3;
  localparam logic [2:0] REP_X8   = 3'd7;

  // Passband: 64 * 4096 numerator base, 64 as the unity value
  localparam logic [20:0] PB_BASE  = 21'h040000;
  localparam logic [15:0] PB_UNITY = 16'd64;

  typedef struct packed {
    logic        vertical;
    logic [11:0] size_in;
    logic [11:0] dst_size;
    logic [11:0] dst_clip;
  } in_item_t;

  typedef struct packed {
    logic [31:0] scale_word;
    logic [31:0] clip_word;
    logic [31:0] passband_word;
    logic [12:0] source_extent;
  } out_item_t;

endpackage

// File: hdl/resize_scale_factor_calc_core.sv
// Resize scale-step calculator. A request is taken on start while busy is low; busy then
// stays high until the result is out. The result appears on out_item for exactly one cycle
// with out_strobe high and cannot be held off, so the receiver must take it in that cycle.
// All work runs through one restoring divider that retires one quotient bit per cycle over
// a numerator of max(SIZE_BITS+12, 21) bits (24 at SIZE_BITS=12). Each division runs
// ST_SEL (setup), ST_DIV and ST_FIN (writeback); a skipped passband job adds an ST_SEL.
// A request needs one to three divisions (repeat check on upscales in the repeat variant,
// scale step unless the sizes are equal, passband on nonzero steps that are not upscales
// in the passband variant, source extent); busy drops in the strobe cycle. The variant
// register is written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this.
`include "resize_scale_factor_calc_core_defines.svh"

module resize_scale_factor_calc_core #(
  parameter int SIZE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  rsfc_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output rsfc_pkg::out_item_t out_item
);
  import rsfc_pkg::*;

  localparam int NUM_W  = (SIZE_BITS + 12 > 21) ? SIZE_BITS + 12 : 21;
  localparam int DEN_W  = 16;
  localparam int MR_W   = NUM_W - 12;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);
  localparam logic [NUM_W-1:0] EXT_LIMIT = NUM_W'(1) << SIZE_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Division jobs
  localparam logic [1:0] OP_REP  = 2'd0;
  localparam logic [1:0] OP_MAIN = 2'd1;
  localparam logic [1:0] OP_PB   = 2'd2;
  localparam logic [1:0] OP_EXT  = 2'd3;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           variant_r, variant_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [1:0]           nop_r, nop_nxt;
  logic                 high_r, high_nxt;
  logic                 up_r, up_nxt;
  logic [SIZE_BITS-1:0] si_r, si_nxt;
  logic [SIZE_BITS-1:0] so_r, so_nxt;
  logic [SIZE_BITS-1:0] co_r, co_nxt;
  logic [3:0]           mant_r, mant_nxt;
  logic [11:0]          frac_r, frac_nxt;
  logic [2:0]           rep_r, rep_nxt;
  logic [15:0]          pb_r, pb_nxt;
  logic [SIZE_BITS:0]   ext_r, ext_nxt;
  logic [NUM_W-1:0]     dq_r, dq_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [31:0]          scale_img_r, scale_img_nxt;
  logic [31:0]          clip_img_r, clip_img_nxt;
  logic [31:0]          pb_img_r, pb_img_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 out_strobe_r, out_strobe_nxt;

  logic                 accept;
  logic [SIZE_BITS-1:0] in_si, in_so, in_co;
  logic [SIZE_BITS-1:0] si_dec;
  logic [2*SIZE_BITS-1:0] prod;
  logic [20:0]          pb_num;

  logic [DEN_W:0]       rem_sh;
  logic                 div_ge;
  logic [DEN_W:0]       rem_diff;

  logic [MR_W-1:0]      mant_raw;
  logic [11:0]          frac_raw;
  logic [11:0]          frac_grid;
  logic [12:0]          frac_inc;
  logic [MR_W:0]        mant_wide;
  logic [11:0]          frac_rnd;
  logic [3:0]           mant_fix;
  logic [11:0]          frac_fix;
  logic [2:0]           rep_dec;
  logic [SIZE_BITS:0]   ext_sum;
  logic [SIZE_BITS:0]   ext_calc;
  logic [15:0]          scale_half, clip_half;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Inputs cut to the configured size width
  assign in_si = in_item.size_in[SIZE_BITS-1:0];
  assign in_so = in_item.dst_size[SIZE_BITS-1:0];
  assign in_co = in_item.dst_clip[SIZE_BITS-1:0];

  assign si_dec = (si_r != '0) ? si_r - SIZE_BITS'(1) : '0;
  assign prod   = si_r * co_r;

  // Passband numerator scaled by 1, 2 or 4 with the mantissa
  always_comb begin
    if (mant_r[3]) begin
      pb_num = PB_BASE << 2;
    end else if (mant_r[2]) begin
      pb_num = PB_BASE << 1;
    end else begin
      pb_num = PB_BASE;
    end
  end

  // Restoring divider step: one quotient bit per cycle.
  // A zero divisor yields an all-ones quotient, which saturates the extent.
  assign rem_sh   = {rem_r, dq_r[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign div_ge   = (rem_sh >= {1'b0, den_r});

  // Scale-step rounding on the grid of 8, then saturation
  assign mant_raw  = dq_r[NUM_W-1:12];
  assign frac_raw  = dq_r[11:0];
  assign frac_grid = {dq_r[11:3], 3'b000};
  assign frac_inc  = {1'b0, frac_grid} + 13'd8;

  always_comb begin
    mant_wide = {1'b0, mant_raw};
    frac_rnd  = frac_raw;
    if (frac_raw[2:0] != 3'b000) begin
      if (up_r) begin
        frac_rnd = (frac_grid >= 12'd8) ? frac_grid - 12'd8 : 12'd0;
      end else if (frac_inc[12]) begin
        frac_rnd  = 12'd0;
        mant_wide = mant_wide + (MR_W+1)'(1);
      end else begin
        frac_rnd = frac_inc[11:0];
      end
    end
    if (mant_wide[MR_W:4] != '0) begin
      mant_fix = MANT_MAX;
      frac_fix = FRAC_GRID;
    end else begin
      mant_fix = mant_wide[3:0];
      frac_fix = frac_rnd;
    end
  end

  // Exact-repeat detection on power-of-two fractions
  always_comb begin
    case (frac_grid)
      FRAC_HALF:    rep_dec = REP_X2;
      FRAC_QUARTER: rep_dec = REP_X4;
      FRAC_EIGHTH:  rep_dec = REP_X8;
      default:      rep_dec = REP_NONE;
    endcase
  end

  // Source extent: align up to four, saturate at the full size
  assign ext_sum = dq_r[SIZE_BITS:0] + (SIZE_BITS+1)'(3);
  always_comb begin
    if (dq_r > EXT_LIMIT) begin
      ext_calc = {1'b1, {SIZE_BITS{1'b0}}};
    end else begin
      ext_calc = {ext_sum[SIZE_BITS:2], 2'b00};
    end
  end

  assign scale_half = {mant_r, frac_r};
  assign clip_half  = {1'b0, rep_r, 12'(co_r)};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    variant_nxt    = variant_r;
    op_nxt         = op_r;
    nop_nxt        = nop_r;
    high_nxt       = high_r;
    up_nxt         = up_r;
    si_nxt         = si_r;
    so_nxt         = so_r;
    co_nxt         = co_r;
    mant_nxt       = mant_r;
    frac_nxt       = frac_r;
    rep_nxt        = rep_r;
    pb_nxt         = pb_r;
    ext_nxt        = ext_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    cnt_nxt        = cnt_r;
    scale_img_nxt  = scale_img_r;
    clip_img_nxt   = clip_img_r;
    pb_img_nxt     = pb_img_r;
    out_item_nxt   = out_item_r;
    out_strobe_nxt = 1'b0;

    if (cfg_we) begin
      variant_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          high_nxt = in_item.vertical;
          si_nxt   = in_si;
          so_nxt   = in_so;
          co_nxt   = in_co;
          up_nxt   = (in_so > in_si);
          rep_nxt  = REP_NONE;
          frac_nxt = 12'd0;
          mant_nxt = (in_co != in_so) ? 4'd1 : 4'd0;
          pb_nxt   = PB_UNITY;
          if (in_si == in_so) begin
            nop_nxt = OP_PB;
          end else if (variant_r == VAR_REPEAT && in_so > in_si) begin
            nop_nxt = OP_REP;
          end else begin
            nop_nxt = OP_MAIN;
          end
          state_nxt = ST_SEL;
        end
      end

      // Load the divider for the next job, or skip a passband job that does not apply
      ST_SEL: begin
        op_nxt    = nop_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
        case (nop_r)
          OP_REP: begin
            dq_nxt  = NUM_W'({si_r, 12'h000});
            den_nxt = DEN_W'(so_r);
          end
          OP_MAIN: begin
            dq_nxt  = NUM_W'({si_dec, 12'h000});
            den_nxt = DEN_W'(so_r) + DEN_W'(1);
          end
          OP_PB: begin
            if (variant_r == VAR_PASSBAND && !up_r && {mant_r, frac_r} != 16'd0) begin
              dq_nxt  = NUM_W'(pb_num);
              den_nxt = {mant_r, frac_r};
            end else begin
              nop_nxt   = OP_EXT;
              state_nxt = ST_SEL;
            end
          end
          default: begin
            dq_nxt  = NUM_W'(prod);
            den_nxt = DEN_W'(so_r);
          end
        endcase
      end

      ST_DIV: begin
        dq_nxt  = {dq_r[NUM_W-2:0], div_ge};
        rem_nxt = div_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end

      // Take the quotient of the finished job
      ST_FIN: begin
        state_nxt = ST_SEL;
        case (op_r)
          OP_REP: begin
            if (rep_dec != REP_NONE) begin
              mant_nxt = dq_r[15:12];
              frac_nxt = frac_grid;
              rep_nxt  = rep_dec;
              nop_nxt  = OP_PB;
            end else begin
              nop_nxt = OP_MAIN;
            end
          end
          OP_MAIN: begin
            mant_nxt = mant_fix;
            frac_nxt = frac_fix;
            nop_nxt  = OP_PB;
          end
          OP_PB: begin
            pb_nxt  = dq_r[15:0];
            nop_nxt = OP_EXT;
          end
          default: begin
            ext_nxt   = ext_calc;
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Merge halves into the kept images and present the beat
      ST_DONE: begin
        if (high_r) begin
          scale_img_nxt = {scale_half, scale_img_r[15:0]};
          clip_img_nxt  = {clip_half, clip_img_r[15:0]};
          if (variant_r == VAR_PASSBAND) begin
            pb_img_nxt = {pb_r, pb_img_r[15:0]};
          end
        end else begin
          scale_img_nxt = {scale_img_r[31:16], scale_half};
          clip_img_nxt  = {clip_img_r[31:16], clip_half};
          if (variant_r == VAR_PASSBAND) begin
            pb_img_nxt = {pb_img_r[31:16], pb_r};
          end
        end
        out_item_nxt.scale_word    = scale_img_nxt;
        out_item_nxt.clip_word     = clip_img_nxt;
        out_item_nxt.passband_word = pb_img_nxt;
        out_item_nxt.source_extent = 13'(ext_r);
        out_strobe_nxt             = 1'b1;
        state_nxt                  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and kept state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      variant_r    <= VAR_BASIC;
      out_strobe_r <= 1'b0;
      scale_img_r  <= '0;
      clip_img_r   <= '0;
      pb_img_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      variant_r    <= variant_nxt;
      out_strobe_r <= out_strobe_nxt;
      scale_img_r  <= scale_img_nxt;
      clip_img_r   <= clip_img_nxt;
      pb_img_r     <= pb_img_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    nop_r      <= nop_nxt;
    high_r     <= high_nxt;
    up_r       <= up_nxt;
    si_r       <= si_nxt;
    so_r       <= so_nxt;
    co_r       <= co_nxt;
    mant_r     <= mant_nxt;
    frac_r     <= frac_nxt;
    rep_r      <= rep_nxt;
    pb_r       <= pb_nxt;
    ext_r      <= ext_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  // Checks
  `RSFC_ASSERT_NXT(a_accept_busy, accept, busy)
  `RSFC_ASSERT_NXT(a_strobe_single, out_strobe_r, !out_strobe_r)
  `RSFC_ASSERT_NXT(a_done_strobe, state_r == ST_DONE, out_strobe_r && !busy)
  `RSFC_ASSERT_IMP(a_frac_grid, state_r == ST_DONE, frac_r[2:0] == 3'b000)
  `RSFC_ASSERT_IMP(a_ext_limit, state_r == ST_DONE, ext_r <= {1'b1, {SIZE_BITS{1'b0}}})

endmodule
